// ===== sv/necir_pkg.sv =====
// ============================================================================
// necir_pkg
// Shared types and constants for the NEC-style IR pulse/space decoder.
// ============================================================================
`default_nettype none

package necir_pkg;

    localparam int UNIT_W  = 20;
    localparam int BOUND_W = 27;
    localparam int DUR_W   = 32;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 20'd562500;

    localparam logic [1:0] REQ_TIMING = 2'd0;
    localparam logic [1:0] REQ_RESET  = 2'd1;

    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_KEY    = 2'd1;
    localparam logic [1:0] OUT_REPEAT = 2'd2;
    localparam logic [1:0] OUT_ERROR  = 2'd3;

    localparam logic [1:0] KIND_NEC = 2'd0;
    localparam logic [1:0] KIND_EXT = 2'd1;
    localparam logic [1:0] KIND_RAW = 2'd2;

    // strict window bounds: lo < d < hi (trl has only a lower bound: lo < d)
    typedef struct packed {
        logic [BOUND_W-1:0] hdr16_lo;
        logic [BOUND_W-1:0] hdr16_hi;
        logic [BOUND_W-1:0] hdr8_lo;
        logic [BOUND_W-1:0] hdr8_hi;
        logic [BOUND_W-1:0] hsp8_lo;
        logic [BOUND_W-1:0] hsp8_hi;
        logic [BOUND_W-1:0] rep4_lo;
        logic [BOUND_W-1:0] rep4_hi;
        logic [BOUND_W-1:0] bit1_lo;
        logic [BOUND_W-1:0] bit1_hi;
        logic [BOUND_W-1:0] bit3_lo;
        logic [BOUND_W-1:0] bit3_hi;
        logic [BOUND_W-1:0] trl_lo;
    } bounds_t;

    typedef struct packed {
        logic hdr16;
        logic hdr8;
        logic hsp8;
        logic rep4;
        logic bit1;
        logic bit3;
        logic trl;
    } dur_flags_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       is_pulse;
        dur_flags_t flags;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic bounds_t unit_bounds(input logic [UNIT_W-1:0] u);
        bounds_t            b;
        logic [BOUND_W-1:0] uu;
        logic [BOUND_W-1:0] hh;
        uu = BOUND_W'(u);
        hh = BOUND_W'(u[UNIT_W-1:1]);
        b.hdr16_lo = uu * BOUND_W'(14);
        b.hdr16_hi = uu * BOUND_W'(18);
        b.hdr8_lo  = (uu << 3) - hh;
        b.hdr8_hi  = (uu << 3) + hh;
        b.hsp8_lo  = uu * BOUND_W'(7);
        b.hsp8_hi  = uu * BOUND_W'(9);
        b.rep4_lo  = (uu << 2) - hh;
        b.rep4_hi  = (uu << 2) + hh;
        b.bit1_lo  = uu - hh;
        b.bit1_hi  = uu + hh;
        b.bit3_lo  = uu * BOUND_W'(3) - hh;
        b.bit3_hi  = uu * BOUND_W'(3) + hh;
        b.trl_lo   = uu * BOUND_W'(65) - hh;
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/necir_front.sv =====
// ============================================================================
// necir_front
// Holds the timing bounds and classifies each incoming duration.
// ============================================================================
`default_nettype none

module necir_front
    import necir_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [UNIT_W-1:0] cfg_unit,
    input  wire logic              in_valid,
    input  wire logic [1:0]        req_type,
    input  wire logic              is_pulse,
    input  wire logic [DUR_W-1:0]  duration_ns,
    input  wire q_stat_t           q_stat,
    output logic                   push,
    output q_entry_t               push_entry
);

    bounds_t    bounds_reg;
    dur_flags_t flags;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bounds_reg <= unit_bounds(UNIT_RESET);
        end
        else if (cfg_valid) begin
            bounds_reg <= unit_bounds(cfg_unit);
        end
    end

    always_comb begin
        flags.hdr16 = (DUR_W'(bounds_reg.hdr16_lo) < duration_ns)
                    && (duration_ns < DUR_W'(bounds_reg.hdr16_hi));
        flags.hdr8  = (DUR_W'(bounds_reg.hdr8_lo) < duration_ns)
                    && (duration_ns < DUR_W'(bounds_reg.hdr8_hi));
        flags.hsp8  = (DUR_W'(bounds_reg.hsp8_lo) < duration_ns)
                    && (duration_ns < DUR_W'(bounds_reg.hsp8_hi));
        flags.rep4  = (DUR_W'(bounds_reg.rep4_lo) < duration_ns)
                    && (duration_ns < DUR_W'(bounds_reg.rep4_hi));
        flags.bit1  = (DUR_W'(bounds_reg.bit1_lo) < duration_ns)
                    && (duration_ns < DUR_W'(bounds_reg.bit1_hi));
        flags.bit3  = (DUR_W'(bounds_reg.bit3_lo) < duration_ns)
                    && (duration_ns < DUR_W'(bounds_reg.bit3_hi));
        flags.trl   = DUR_W'(bounds_reg.trl_lo) < duration_ns;
    end

    assign push                = in_valid && !q_stat.full;
    assign push_entry.req_type = req_type;
    assign push_entry.is_pulse = is_pulse;
    assign push_entry.flags    = flags;

endmodule

`default_nettype wire

// ===== sv/necir_queue.sv =====
// ============================================================================
// necir_queue
// Small FIFO of classified requests between front and back.
// ============================================================================
`default_nettype none

module necir_queue
    import necir_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      head,
    output q_stat_t       q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/necir_back.sv =====
// ============================================================================
// necir_back
// NEC frame state machine and registered result stage.
// ============================================================================
`default_nettype none

module necir_back
    import necir_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_entry_t head,
    input  wire q_stat_t  q_stat,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [1:0]    outcome,
    output logic [31:0]   scancode,
    output logic [1:0]    protocol_kind
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_SPACE,
        S_BIT_PULSE,
        S_BIT_SPACE,
        S_TRL_PULSE,
        S_TRL_SPACE
    } state_t;

    localparam logic [5:0] FRAME_BITS = 6'd32;

    state_t      state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next, cnt_inc;
    logic [31:0] shift_reg, shift_next, shift_up;
    logic        short_hdr_reg, short_hdr_next;
    logic        armed_reg, armed_next;
    logic        out_valid_reg;
    logic [1:0]  outcome_reg, outcome_next;
    logic [31:0] code_reg, code_next;
    logic [1:0]  kind_reg, kind_next;
    logic        err;
    logic [7:0]  byte_a, byte_na, byte_c, byte_nc;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    assign pop      = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign cnt_inc  = cnt_reg + 6'd1;
    assign shift_up = {shift_reg[30:0], 1'b0};
    assign byte_a   = rev8(shift_reg[31:24]);
    assign byte_na  = rev8(shift_reg[23:16]);
    assign byte_c   = rev8(shift_reg[15:8]);
    assign byte_nc  = rev8(shift_reg[7:0]);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        short_hdr_next = short_hdr_reg;
        armed_next     = armed_reg;
        outcome_next   = OUT_NONE;
        code_next      = '0;
        kind_next      = KIND_NEC;
        err            = 1'b0;
        if (head.req_type == REQ_RESET) begin
            state_next = S_IDLE;
        end
        else if (head.req_type == REQ_TIMING) begin
            unique case (state_reg)
                S_IDLE: begin
                    if (!head.is_pulse) begin
                        err = 1'b1;
                    end
                    else if (head.flags.hdr16) begin
                        short_hdr_next = 1'b0;
                        armed_next     = 1'b0;
                        cnt_next       = '0;
                        state_next     = S_HDR_SPACE;
                    end
                    else if (head.flags.hdr8) begin
                        short_hdr_next = 1'b1;
                        cnt_next       = '0;
                        state_next     = S_HDR_SPACE;
                    end
                    else begin
                        err = 1'b1;
                    end
                end
                S_HDR_SPACE: begin
                    if (head.is_pulse) begin
                        err = 1'b1;
                    end
                    else if (head.flags.hsp8) begin
                        state_next = S_BIT_PULSE;
                    end
                    else if (head.flags.rep4) begin
                        outcome_next = OUT_REPEAT;
                    end
                    else begin
                        err = 1'b1;
                    end
                end
                S_BIT_PULSE: begin
                    if (!head.is_pulse || !head.flags.bit1) begin
                        err = 1'b1;
                    end
                    else begin
                        state_next = S_BIT_SPACE;
                    end
                end
                S_BIT_SPACE: begin
                    if (head.is_pulse) begin
                        err = 1'b1;
                    end
                    else if (armed_reg && cnt_reg == 6'd1 && head.flags.trl) begin
                        // repeat after a short header: one bit then a long gap
                        outcome_next = OUT_REPEAT;
                        state_next   = S_IDLE;
                    end
                    else begin
                        if (cnt_reg > 6'd1) begin
                            armed_next = 1'b0;
                        end
                        shift_next = shift_up;
                        if (head.flags.bit3) begin
                            shift_next = shift_up | 32'd1;
                        end
                        if (!head.flags.bit3 && !head.flags.bit1) begin
                            err = 1'b1;
                        end
                        else begin
                            cnt_next   = cnt_inc;
                            state_next = (cnt_inc == FRAME_BITS) ? S_TRL_PULSE : S_BIT_PULSE;
                        end
                    end
                end
                S_TRL_PULSE: begin
                    if (!head.is_pulse || !head.flags.bit1) begin
                        err = 1'b1;
                    end
                    else begin
                        state_next = S_TRL_SPACE;
                    end
                end
                S_TRL_SPACE: begin
                    if (head.is_pulse || !head.flags.trl) begin
                        err = 1'b1;
                    end
                    else begin
                        if ((byte_c ^ byte_nc) != 8'hFF) begin
                            code_next = shift_reg;
                            kind_next = KIND_RAW;
                        end
                        else if ((byte_a ^ byte_na) != 8'hFF) begin
                            code_next = {8'h00, byte_a, byte_na, byte_c};
                            kind_next = KIND_EXT;
                        end
                        else begin
                            code_next = {16'h0000, byte_a, byte_c};
                            kind_next = KIND_NEC;
                        end
                        if (short_hdr_reg) begin
                            armed_next = 1'b1;
                        end
                        outcome_next = OUT_KEY;
                        state_next   = S_IDLE;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
            if (err) begin
                state_next   = S_IDLE;
                outcome_next = OUT_ERROR;
                code_next    = '0;
                kind_next    = KIND_NEC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            shift_reg     <= '0;
            short_hdr_reg <= 1'b0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            outcome_reg   <= OUT_NONE;
            code_reg      <= '0;
            kind_reg      <= KIND_NEC;
        end
        else begin
            if (pop) begin
                state_reg     <= state_next;
                cnt_reg       <= cnt_next;
                shift_reg     <= shift_next;
                short_hdr_reg <= short_hdr_next;
                armed_reg     <= armed_next;
                out_valid_reg <= 1'b1;
                outcome_reg   <= outcome_next;
                code_reg      <= code_next;
                kind_reg      <= kind_next;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign scancode      = code_reg;
    assign protocol_kind = kind_reg;

endmodule

`default_nettype wire

// ===== sv/nec_ir_pulse_space_decoder.sv =====
// ============================================================================
// nec_ir_pulse_space_decoder
// NEC-style IR frame decoder fed with timed pulse and space requests.
// Each accepted request is stored in the queue; its result is registered when the back end pops it.
// Throughput: one request per cycle while in_stall is low; a queue (two entries by default) decouples front and back.
// Reset: async active low; machine idle, unit 562500 ns, queue and output empty.
// Config: unit_ns takes effect on the edge it is written; cfg_ready is always high.
// ============================================================================
`default_nettype none

module nec_ir_pulse_space_decoder
    import necir_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [UNIT_W-1:0] unit_ns,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        req_type,
    input  wire logic              is_pulse,
    input  wire logic [DUR_W-1:0]  duration_ns,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             outcome,
    output logic [31:0]            scancode,
    output logic [1:0]             protocol_kind
);

    q_stat_t  q_stat;
    q_entry_t push_entry;
    q_entry_t head;
    logic     push;
    logic     pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full;

    necir_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_unit    (unit_ns),
        .in_valid    (in_valid),
        .req_type    (req_type),
        .is_pulse    (is_pulse),
        .duration_ns (duration_ns),
        .q_stat      (q_stat),
        .push        (push),
        .push_entry  (push_entry)
    );

    necir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    necir_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .outcome       (outcome),
        .scancode      (scancode),
        .protocol_kind (protocol_kind)
    );

    a_non_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome != OUT_KEY |-> scancode == 32'd0 && protocol_kind == KIND_NEC)
        else $error("non-key result carries scancode or kind");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> protocol_kind == KIND_NEC || protocol_kind == KIND_EXT
                      || protocol_kind == KIND_RAW)
        else $error("illegal protocol kind");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && q_stat.empty |=> !q_stat.empty)
        else $error("accepted request lost before queue");

    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty && !out_valid |-> pop)
        else $error("back idle while queue holds a request");

endmodule

`default_nettype wire
